FILE: rtl/core/tlnv_pkg.sv
package tlnv_pkg;

   // Line number layout
   localparam int NumberDigits = 6;
   localparam int CountWidth   = 4 * NumberDigits;
   localparam int NumLen       = NumberDigits + 1;   // digits plus tab

   // Output run limits
   localparam int MaxRun       = 12;
   localparam int RunLenWidth  = $clog2(MaxRun + 1);
   localparam int RunSumWidth  = $clog2(NumLen + 1 + 4 + 1);
   localparam int QueueDepth   = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // Register map
   localparam int CsrAddrWidth = 5;
   localparam logic [2:0] RegNumberNonblank = 3'd0;
   localparam logic [2:0] RegNumberAll      = 3'd1;
   localparam logic [2:0] RegSqueezeBlank   = 3'd2;
   localparam logic [2:0] RegMarkLineEnd    = 3'd3;
   localparam logic [2:0] RegShowTab        = 3'd4;
   localparam logic [2:0] RegShowNonprint   = 3'd5;

   // Character codes
   localparam logic [7:0] ChTab      = 8'h09;
   localparam logic [7:0] ChNewline  = 8'h0A;
   localparam logic [7:0] ChSpace    = 8'h20;
   localparam logic [7:0] ChDollar   = 8'h24;
   localparam logic [7:0] ChDash     = 8'h2D;
   localparam logic [7:0] ChZero     = 8'h30;
   localparam logic [7:0] ChQuestion = 8'h3F;
   localparam logic [7:0] ChUpperI   = 8'h49;
   localparam logic [7:0] ChUpperM   = 8'h4D;
   localparam logic [7:0] ChCaret    = 8'h5E;
   localparam logic [6:0] ChDel7     = 7'h7F;
   localparam logic [6:0] ChSpace7   = 7'h20;

   typedef struct packed {
      logic number_nonblank;
      logic number_all;
      logic squeeze_blank;
      logic mark_line_end;
      logic show_tab;
      logic show_nonprint;
   } cfg_type;

   // One expanded run, held between front and back
   typedef struct packed {
      logic [CountWidth-1:0]   count_bcd;
      logic [NumberDigits-1:0] blank;      // leading digit shown as space
      logic                    num_en;
      logic                    dollar_en;
      logic [3:0][7:0]         body;
      logic [RunLenWidth-1:0]  run_len;
   } run_type;

   typedef struct packed {
      logic [1:0][7:0] bytes;
      logic [1:0]      len;
   } vis_type;

   // Caret notation of a 7-bit value; tab and newline pass unless in M- form
   function automatic vis_type vis7(input logic [6:0] c, input logic meta);
      vis_type v;
      v.bytes = '0;
      v.len   = 2'd1;
      if (c == ChDel7) begin
         v.bytes[0] = ChCaret;
         v.bytes[1] = ChQuestion;
         v.len      = 2'd2;
      end else if (c >= ChSpace7) begin
         v.bytes[0] = {1'b0, c};
      end else if (!meta && ({1'b0, c} == ChTab || {1'b0, c} == ChNewline)) begin
         v.bytes[0] = {1'b0, c};
      end else begin
         v.bytes[0] = ChCaret;
         v.bytes[1] = {2'b01, c[5:0]};
         v.len      = 2'd2;
      end
      return v;
   endfunction

endpackage

FILE: rtl/core/tlnv_if.sv
interface tlnv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_file;

   modport source (output valid, output data_byte, output first_of_file, input ready);
   modport sink   (input valid, input data_byte, input first_of_file, output ready);
endinterface

interface tlnv_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: rtl/core/tlnv_csr.sv
module tlnv_csr
   import tlnv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;
   logic       rd_bit;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   // Decode write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            RegNumberNonblank: cfg_in.number_nonblank = csr_pwdata[0];
            RegNumberAll:      cfg_in.number_all      = csr_pwdata[0];
            RegSqueezeBlank:   cfg_in.squeeze_blank   = csr_pwdata[0];
            RegMarkLineEnd:    cfg_in.mark_line_end   = csr_pwdata[0];
            RegShowTab:        cfg_in.show_tab        = csr_pwdata[0];
            RegShowNonprint:   cfg_in.show_nonprint   = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         RegNumberNonblank: rd_bit = cfg_ff.number_nonblank;
         RegNumberAll:      rd_bit = cfg_ff.number_all;
         RegSqueezeBlank:   rd_bit = cfg_ff.squeeze_blank;
         RegMarkLineEnd:    rd_bit = cfg_ff.mark_line_end;
         RegShowTab:        rd_bit = cfg_ff.show_tab;
         RegShowNonprint:   rd_bit = cfg_ff.show_nonprint;
         default:           rd_bit = 1'b0;
      endcase
   end
   assign csr_prdata = {31'b0, rd_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/core/tlnv_front.sv
module tlnv_front
   import tlnv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   tlnv_req_if.sink    req_bus,
   input  logic        q_full,
   output logic        push,
   output run_type     push_entry
);

   logic                  at_line_start_ff, at_line_start_in;
   logic                  prev_nl_ff, prev_nl_in;
   logic                  squeezing_ff, squeezing_in;
   logic [CountWidth-1:0] count_ff, count_in;

   logic [7:0]            c;
   logic                  accept, start, is_nl, squeeze_hit, drop, number;
   logic                  all_nine, carry, lead;
   logic [CountWidth-1:0] bumped;
   logic [3:0]            dig;
   logic [NumberDigits-1:0] blank;
   logic [3:0][7:0]       body;
   logic [2:0]            body_len;
   logic [RunSumWidth-1:0] run_sum;
   vis_type               v;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign c             = req_bus.data_byte;
   assign is_nl         = (c == ChNewline);
   assign start         = at_line_start_ff || req_bus.first_of_file;
   assign squeeze_hit   = start && cfg.squeeze_blank && is_nl && prev_nl_ff;
   assign drop          = squeeze_hit && squeezing_ff;
   assign number        = start && (cfg.number_nonblank ? !is_nl : cfg.number_all);
   assign push          = accept && !drop;

   // Saturating BCD increment
   always_comb begin
      all_nine = 1'b1;
      carry    = 1'b1;
      bumped   = count_ff;
      for (int i = 0; i < NumberDigits; i++) begin
         dig = count_ff[4*i +: 4];
         if (dig != 4'd9) all_nine = 1'b0;
         if (carry) begin
            if (dig >= 4'd9) begin
               bumped[4*i +: 4] = 4'd0;
            end else begin
               bumped[4*i +: 4] = dig + 4'd1;
               carry = 1'b0;
            end
         end
      end
      if (all_nine) bumped = count_ff;
      count_in = number ? bumped : count_ff;
   end

   // Mark leading zeros that print as spaces
   always_comb begin
      lead  = 1'b1;
      blank = '0;
      for (int i = NumberDigits - 1; i >= 0; i--) begin
         if (lead && count_in[4*i +: 4] == 4'd0 && i > 0) begin
            blank[i] = 1'b1;
         end else begin
            lead = 1'b0;
         end
      end
   end

   // Visible form of the byte itself
   always_comb begin
      body     = '0;
      body_len = 3'd1;
      v        = '0;
      if (cfg.show_tab && c == ChTab) begin
         body[0]  = ChCaret;
         body[1]  = ChUpperI;
         body_len = 3'd2;
      end else if (cfg.show_nonprint) begin
         if (c[7]) begin
            v        = vis7(c[6:0], 1'b1);
            body[0]  = ChUpperM;
            body[1]  = ChDash;
            body[2]  = v.bytes[0];
            body[3]  = v.bytes[1];
            body_len = 3'd2 + {1'b0, v.len};
         end else begin
            v        = vis7(c[6:0], 1'b0);
            body[0]  = v.bytes[0];
            body[1]  = v.bytes[1];
            body_len = {1'b0, v.len};
         end
      end else begin
         body[0] = c;
      end
   end

   // Assemble run descriptor, clip length to the run limit
   always_comb begin
      run_sum = (number ? RunSumWidth'(NumLen) : '0)
              + RunSumWidth'(cfg.mark_line_end && is_nl)
              + RunSumWidth'(body_len);
      push_entry.count_bcd = count_in;
      push_entry.blank     = blank;
      push_entry.num_en    = number;
      push_entry.dollar_en = cfg.mark_line_end && is_nl;
      push_entry.body      = body;
      push_entry.run_len   = (run_sum > RunSumWidth'(MaxRun)) ? RunLenWidth'(MaxRun)
                                                             : RunLenWidth'(run_sum);
   end

   // Advance line state on every beat that is not dropped
   always_comb begin
      at_line_start_in = at_line_start_ff;
      prev_nl_in       = prev_nl_ff;
      squeezing_in     = squeezing_ff;
      if (push) begin
         at_line_start_in = is_nl;
         prev_nl_in       = is_nl;
         if (start) squeezing_in = squeeze_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff <= 1'b1;
         prev_nl_ff       <= 1'b1;
         squeezing_ff     <= 1'b0;
         count_ff         <= '0;
      end else begin
         at_line_start_ff <= at_line_start_in;
         prev_nl_ff       <= prev_nl_in;
         squeezing_ff     <= squeezing_in;
         if (push) count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/core/tlnv_queue.sv
module tlnv_queue
   import tlnv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  run_type push_entry,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output run_type head
);

   run_type                  mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntWidth-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == QueueCntWidth'(QueueDepth));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   // Store entry
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("queue underflow");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QueueCntWidth'(QueueDepth)) else $error("queue count out of range");

endmodule

FILE: rtl/core/tlnv_back.sv
module tlnv_back
   import tlnv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  run_type  head,
   output logic     pop,
   tlnv_rsp_if.source rsp_bus
);

   logic [RunLenWidth-1:0] ptr_ff, ptr_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   last_ff, last_in;

   logic                   load, is_last;
   logic [RunLenWidth-1:0] q, bi;
   logic [7:0]             sel_byte;
   logic [3:0]             dig;

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.out_byte    = byte_ff;
   assign rsp_bus.last_of_run = last_ff;

   assign load    = !valid_ff || rsp_bus.ready;
   assign is_last = (ptr_ff == head.run_len - 1'b1);
   assign pop     = load && head_valid && is_last;

   // Pick the byte at the current run position
   always_comb begin
      q        = ptr_ff - (head.num_en ? RunLenWidth'(NumLen) : '0);
      bi       = q - RunLenWidth'(head.dollar_en);
      dig      = '0;
      sel_byte = head.body[bi[1:0]];
      if (head.dollar_en && q == '0) sel_byte = ChDollar;
      if (head.num_en && ptr_ff < RunLenWidth'(NumLen)) begin
         sel_byte = ChTab;
         for (int j = 0; j < NumberDigits; j++) begin
            if (ptr_ff == RunLenWidth'(j)) begin
               dig = head.count_bcd[4*(NumberDigits-1-j) +: 4];
               if (dig > 4'd9) dig = 4'd9;
               sel_byte = head.blank[NumberDigits-1-j] ? ChSpace : (ChZero | {4'b0, dig});
            end
         end
      end
   end

   // Load output stage, step through the run
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      ptr_in   = ptr_ff;
      if (load) begin
         valid_in = head_valid;
         byte_in  = sel_byte;
         last_in  = is_last;
         if (head_valid) ptr_in = is_last ? '0 : ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ptr_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   a_ptr_in_run: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ptr_ff < head.run_len) else $error("run position past run end");
   a_ptr_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> ptr_ff == '0) else $error("run position left over");
   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff && last_ff) else $error("run retired without last beat");

endmodule

FILE: rtl/core/text_line_number_and_visualize.sv
// Channel  | Direction | Payload                        | Handshake
// req_bus  | in        | data_byte[7:0], first_of_file  | valid/ready
// rsp_bus  | out       | out_byte[7:0], last_of_run     | valid/ready
// csr_*    | in/out    | six 1-bit controls at 4*i      | APB, pready tied high
//
// One input beat is taken per cycle while the two-entry run queue has room.
// Each run drains at one output beat per cycle while rsp_bus is ready, 1 to 12 beats per input byte,
// so the sustained input rate is set by the run length at the output stage.
// Dropped blank lines are accepted from req_bus and produce no beat.
// Reset is synchronous; it clears line state, count, queue and controls.
// Either side may stall freely; the queue and the output register part them.
module text_line_number_and_visualize
   import tlnv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   tlnv_req_if.sink                req_bus,
   tlnv_rsp_if.source              rsp_bus,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   cfg_type cfg;
   logic    push, pop, q_full, head_valid;
   run_type push_entry, head;

   tlnv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tlnv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_bus    (req_bus),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   tlnv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head)
   );

   tlnv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule
